@@ hdl/keyword_stream_matcher_macros.svh @@
// ----------------------------------------------------------------------------
// keyword_stream_matcher_macros
// assertion macros shared by the keyword matcher, clocked on clock and
// disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef KEYWORD_STREAM_MATCHER_MACROS_SVH
`define KEYWORD_STREAM_MATCHER_MACROS_SVH

// same-cycle implication
`define KSM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyword matcher check failed");

// next-cycle implication
`define KSM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyword matcher check failed");

`endif

@@ hdl/ksm_pkg.sv @@
// ----------------------------------------------------------------------------
// ksm_pkg
// constants and keyword letter table of the keyword stream matcher
// ----------------------------------------------------------------------------
package ksm_pkg;

   localparam int DEF_NUM_KEYWORDS = 20;
   localparam int DEF_KEYWORD_LEN  = 4;

   // keywords and letters actually held in the table, the rest read as zero
   localparam int KW_STORED  = 20;
   localparam int KW_LETTERS = 4;

   localparam int BYTE_W = 8;
   localparam int CODE_W = 5;

   localparam logic FUNC_MATCH = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   function automatic logic [BYTE_W-1:0] kw_letter(input int unsigned row,
                                                   input int unsigned col);
      logic [KW_LETTERS*BYTE_W-1:0] word;
      logic [BYTE_W-1:0]            letter;
      unique case (row)
         0:       word = "RESE";
         1:       word = "BLAC";
         2:       word = "SENG";
         3:       word = "SPHY";
         4:       word = "BLOB";
         5:       word = "XBLB";
         6:       word = "SCEN";
         7:       word = "SHOW";
         8:       word = "UPDA";
         9:       word = "TRIG";
         10:      word = "INTR";
         11:      word = "QUEU";
         12:      word = "SETV";
         13:      word = "GETV";
         14:      word = "LOAD";
         15:      word = "SAVE";
         16:      word = "ERAS";
         17:      word = "DUMP";
         18:      word = "BRIG";
         19:      word = "DEBU";
         default: word = '0;
      endcase
      letter = '0;
      // first letter sits in the top byte of the string
      for (int unsigned c = 0; c < KW_LETTERS; c++) begin
         if (c == col) begin
            letter = word[(KW_LETTERS-1-c)*BYTE_W +: BYTE_W];
         end
      end
      return letter;
   endfunction

endpackage

@@ hdl/ksm_req_if.sv @@
// ----------------------------------------------------------------------------
// ksm_req_if
// input channel of the keyword matcher: one function code and one byte
// ----------------------------------------------------------------------------
interface ksm_req_if import ksm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [BYTE_W-1:0] byte_in;

   modport source (output valid, output func, output byte_in, input ready);
   modport sink   (input valid, input func, input byte_in, output ready);
endinterface

@@ hdl/ksm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ksm_rsp_if
// result channel of the keyword matcher: one match code per input word
// ----------------------------------------------------------------------------
interface ksm_rsp_if import ksm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] keyword_code;

   modport source (output valid, output keyword_code, input ready);
   modport sink   (input valid, input keyword_code, output ready);
endinterface

@@ hdl/ksm_eval.sv @@
// ----------------------------------------------------------------------------
// ksm_eval
// per-byte keyword comparators and first-completion priority pick
// ----------------------------------------------------------------------------
module ksm_eval import ksm_pkg::*; #(
   parameter int NUM_KEYWORDS = DEF_NUM_KEYWORDS,
   parameter int KEYWORD_LEN  = DEF_KEYWORD_LEN,
   parameter int PW           = (KEYWORD_LEN > 1) ? $clog2(KEYWORD_LEN) : 1
) (
   input  logic [NUM_KEYWORDS-1:0][PW-1:0] prog_cur,
   input  logic [BYTE_W-1:0]               byte_in,
   output logic [NUM_KEYWORDS-1:0][PW-1:0] prog_nxt,
   output logic [CODE_W-1:0]               keyword_code
);

   logic [NUM_KEYWORDS-1:0] hit;
   logic [NUM_KEYWORDS-1:0] done;

   // letter expected next by each keyword
   always_comb begin
      logic [BYTE_W-1:0] letter;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         letter = '0;
         for (int c = 0; c < KEYWORD_LEN; c++) begin
            if (prog_cur[i] == PW'(c)) begin
               letter = kw_letter(i, c);
            end
         end
         hit[i]  = (letter == byte_in);
         done[i] = hit[i] && (prog_cur[i] == PW'(KEYWORD_LEN - 1));
      end
   end

   // keywords after the first completion keep their progress
   always_comb begin
      logic found;
      found        = 1'b0;
      keyword_code = '0;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         prog_nxt[i] = prog_cur[i];
         if (!found) begin
            if (done[i]) begin
               prog_nxt[i]  = '0;
               keyword_code = CODE_W'(i + 1);
               found        = 1'b1;
            end else if (hit[i]) begin
               prog_nxt[i] = prog_cur[i] + PW'(1);
            end else begin
               prog_nxt[i] = '0;
            end
         end
      end
   end

endmodule

@@ hdl/keyword_stream_matcher.sv @@
// ----------------------------------------------------------------------------
// keyword_stream_matcher
// recognizes fixed four-letter command keywords in a received byte stream
// ----------------------------------------------------------------------------
// req_chan carries one word per byte: func selects match (byte_in is compared
// against every keyword) or clear (all keyword progress goes to zero).
// rsp_chan returns exactly one keyword_code per request word, in order:
// 0 when nothing completed, k when the keyword in table row k-1 completed.
// A request word lands in the input register; the comparators and the
// priority pick then work on it, and the result register loads their output
// once that register is free or being emptied, so every result is registered.
// Throughput is one word per cycle while rsp_chan does not stall; the single
// pass through the comparators and the twenty-deep priority pick sets it.
// When rsp_chan stalls the result register holds, the input register still
// takes one more word, and req_chan.ready drops only when both are full.
// Synchronous reset empties both registers and clears all keyword progress.
// ----------------------------------------------------------------------------
`include "keyword_stream_matcher_macros.svh"

module keyword_stream_matcher import ksm_pkg::*; #(
   parameter int NUM_KEYWORDS = DEF_NUM_KEYWORDS,
   parameter int KEYWORD_LEN  = DEF_KEYWORD_LEN
) (
   input logic      clock,
   input logic      reset,
   ksm_req_if.sink  req_chan,
   ksm_rsp_if.source rsp_chan
);

   localparam int PW = (KEYWORD_LEN > 1) ? $clog2(KEYWORD_LEN) : 1;

   logic                           in_valid_ff, in_valid_in;
   logic                           in_func_ff;
   logic [BYTE_W-1:0]              in_byte_ff;
   logic                           out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]              out_code_ff, out_code_in;
   logic [NUM_KEYWORDS-1:0][PW-1:0] prog_ff, prog_in;
   logic [NUM_KEYWORDS-1:0][PW-1:0] prog_eval;
   logic [CODE_W-1:0]              code_eval;
   logic                           advance;
   logic                           process;
   logic                           req_take;

   ksm_eval #(
      .NUM_KEYWORDS(NUM_KEYWORDS),
      .KEYWORD_LEN (KEYWORD_LEN),
      .PW          (PW)
   ) u_eval (
      .prog_cur    (prog_ff),
      .byte_in     (in_byte_ff),
      .prog_nxt    (prog_eval),
      .keyword_code(code_eval)
   );

   // result register free or being emptied this cycle
   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign process  = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.keyword_code = out_code_ff;

   always_comb begin
      in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      out_code_in  = out_code_ff;
      prog_in      = prog_ff;
      if (process) begin
         if (in_func_ff == FUNC_CLEAR) begin
            prog_in     = '0;
            out_code_in = '0;
         end else begin
            prog_in     = prog_eval;
            out_code_in = code_eval;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prog_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         prog_ff      <= prog_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_chan.func;
         in_byte_ff <= req_chan.byte_in;
      end
      out_code_ff <= out_code_in;
   end

   `KSM_ASSERT_NEXT(a_clear_zeroes, process && (in_func_ff == FUNC_CLEAR),
                    (prog_ff == '0) && out_valid_ff && (out_code_ff == '0))
   `KSM_ASSERT_NOW(a_code_range, out_valid_ff, out_code_ff <= CODE_W'(NUM_KEYWORDS))
   `KSM_ASSERT_NOW(a_full_blocks, in_valid_ff && out_valid_ff && !rsp_chan.ready,
                   !req_chan.ready)
   `KSM_ASSERT_NOW(a_reset_clears, $past(reset), (prog_ff == '0) && !out_valid_ff)

endmodule
